### rtl/wsfp_pkg.sv
// Package for the WebSocket frame parser.
// Holds result kinds, parse phases, the result record and the queue depth.
// No dependencies.
`default_nettype none

package wsfp_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h0F;
    localparam logic [6:0] LEN_EXT16   = 7'd126;
    localparam logic [6:0] LEN_EXT64   = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_TRUNC   = 2'd2
    } t_kind;

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_KEY  = 6'b001000,
        PH_PAY  = 6'b010000,
        PH_SKIP = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        fin_flag;
        logic [3:0]  frame_opcode;
        logic        masked_flag;
        logic [63:0] frame_length;
        logic        last;
    } t_result;

    function automatic t_result make_result(
        input t_kind       kind,
        input logic [7:0]  pb,
        input logic        fin,
        input logic [3:0]  opcode,
        input logic        masked,
        input logic [63:0] len
    );
        t_result r;
        r.kind         = kind;
        r.payload_byte = pb;
        r.fin_flag     = fin;
        r.frame_opcode = opcode;
        r.masked_flag  = masked;
        r.frame_length = len;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/wsfp_if.sv
// Valid/ready channel interfaces for the WebSocket frame parser.
// Input beat carries one buffer byte; output beat carries one result.
// No dependencies.
`default_nettype none

interface wsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface wsfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] frame_length;
    logic        last;

    modport source (output valid, output kind, output payload_byte, output fin_flag,
                    output frame_opcode, output masked_flag, output frame_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input fin_flag,
                    input frame_opcode, input masked_flag, input frame_length,
                    input last, output ready);
endinterface

`default_nettype wire

### rtl/websocket_frame_parser_core.sv
// WebSocket frame parser top level: header decode, unmasking, result queue.
// Depends on wsfp_pkg and the channel interfaces in wsfp_if.sv.
// Each result is written into the result queue when its input beat is taken.
// Throughput: one byte per cycle while the queue has room for two results;
// a byte that yields two results (last payload byte plus frame complete, or
// a non-final payload byte plus truncation) fills two of QUEUE_DEPTH entries.
// Reset: synchronous, active low; parser returns to the first header byte.
`default_nettype none

module websocket_frame_parser_core #(
    parameter int QUEUE_DEPTH = wsfp_pkg::QUEUE_DEPTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    wsfp_in_if.sink      i_in,
    wsfp_out_if.source   o_out
);
    import wsfp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(QUEUE_DEPTH - 2);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_ecnt, n_ecnt;
    logic [3:0]  r_need, n_need;
    logic        r_fin, n_fin;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [7:0]  r_key [4];
    logic [7:0]  n_key [4];
    logic [63:0] r_pidx, n_pidx;

    t_result     res [2];
    logic [1:0]  nres;

    t_result           r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  wr_ptr1;

    logic in_acc, out_acc;
    logic [7:0] b;
    logic [6:0] len7;
    logic [7:0] key_byte;
    logic do_len_done, do_hdr_done;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count <= CNT_ROOM2);
    assign b          = i_in.data_byte;
    assign len7       = b[6:0];
    assign key_byte   = r_masked ? r_key[r_pidx[1:0]] : 8'h00;

    always_comb begin
        n_phase  = r_phase;
        n_ecnt   = r_ecnt;
        n_need   = r_need;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_len    = r_len;
        n_key    = r_key;
        n_pidx   = r_pidx;
        nres     = 2'd0;
        res[0]   = make_result(KIND_TRUNC, 8'h00, 1'b0, 4'h0, 1'b0, 64'h0);
        res[1]   = res[0];
        do_len_done = 1'b0;
        do_hdr_done = 1'b0;

        case (r_phase)
            PH_HDR0: begin
                n_fin    = |(b & FIN_BIT);
                n_opcode = 4'(b & OPCODE_MASK);
                n_masked = 1'b0;
                n_len    = 64'h0;
                n_pidx   = 64'h0;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = b[7];
                n_len    = 64'h0;
                n_ecnt   = 4'd0;
                if (len7 == LEN_EXT16) begin
                    n_need  = EXT16_BYTES;
                    n_phase = PH_EXT;
                end else if (len7 == LEN_EXT64) begin
                    n_need  = EXT64_BYTES;
                    n_phase = PH_EXT;
                end else begin
                    n_need      = 4'd0;
                    n_len       = {57'h0, len7};
                    do_len_done = 1'b1;
                end
            end
            PH_EXT: begin
                n_len  = {r_len[55:0], b};
                n_ecnt = r_ecnt + 4'd1;
                if (n_ecnt >= r_need) begin
                    do_len_done = 1'b1;
                end
            end
            PH_KEY: begin
                n_key[r_ecnt[1:0]] = b;
                n_ecnt = r_ecnt + 4'd1;
                if (n_ecnt >= KEY_BYTES) begin
                    do_hdr_done = 1'b1;
                end
            end
            PH_PAY: begin
                res[0] = make_result(KIND_PAYLOAD, b ^ key_byte, r_fin, r_opcode,
                                     r_masked, r_len);
                nres   = 2'd1;
                n_pidx = r_pidx + 64'd1;
                if (n_pidx >= r_len) begin
                    res[1]  = make_result(KIND_DONE, 8'h00, r_fin, r_opcode,
                                          r_masked, r_len);
                    nres    = 2'd2;
                    n_phase = PH_SKIP;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase

        if (do_len_done) begin
            if (n_masked) begin
                n_ecnt  = 4'd0;
                n_phase = PH_KEY;
            end else begin
                do_hdr_done = 1'b1;
            end
        end

        if (do_hdr_done) begin
            n_pidx = 64'h0;
            if (n_len == 64'h0) begin
                res[0]  = make_result(KIND_DONE, 8'h00, n_fin, n_opcode, n_masked, n_len);
                nres    = 2'd1;
                n_phase = PH_SKIP;
            end else begin
                n_phase = PH_PAY;
            end
        end

        if (i_in.end_of_buffer) begin
            if (n_phase != PH_SKIP) begin
                res[nres[0]] = make_result(KIND_TRUNC, 8'h00, 1'b0, 4'h0, 1'b0, 64'h0);
                nres = nres + 2'd1;
            end
            n_phase = PH_HDR0;
            n_ecnt  = 4'd0;
            n_need  = 4'd0;
            n_pidx  = 64'h0;
        end

        if (nres == 2'd1) begin
            res[0].last = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_ecnt   <= 4'd0;
            r_need   <= 4'd0;
            r_fin    <= 1'b0;
            r_opcode <= 4'h0;
            r_masked <= 1'b0;
            r_len    <= 64'h0;
            r_key    <= '{default: 8'h00};
            r_pidx   <= 64'h0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_ecnt   <= n_ecnt;
            r_need   <= n_need;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_key    <= n_key;
            r_pidx   <= n_pidx;
        end
    end

    assign wr_ptr1 = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (nres != 2'd0) begin
                r_queue[r_wr_ptr] <= res[0];
            end
            if (nres == 2'd2) begin
                r_queue[wr_ptr1] <= res[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                if (nres == 2'd1) begin
                    r_wr_ptr <= wr_ptr1;
                end else if (nres == 2'd2) begin
                    r_wr_ptr <= (wr_ptr1 == PTR_LAST) ? '0 : wr_ptr1 + PTR_W'(1);
                end
            end
            if (out_acc) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (in_acc ? CNT_W'(nres) : '0) - CNT_W'(out_acc);
        end
    end

    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = r_queue[r_rd_ptr].kind;
    assign o_out.payload_byte = r_queue[r_rd_ptr].payload_byte;
    assign o_out.fin_flag     = r_queue[r_rd_ptr].fin_flag;
    assign o_out.frame_opcode = r_queue[r_rd_ptr].frame_opcode;
    assign o_out.masked_flag  = r_queue[r_rd_ptr].masked_flag;
    assign o_out.frame_length = r_queue[r_rd_ptr].frame_length;
    assign o_out.last         = r_queue[r_rd_ptr].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("result queue overflow");

    a_pay_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_PAY) |=> o_out.valid)
        else $error("payload beat produced no result");

    a_eob_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.end_of_buffer) |=> (r_phase == PH_HDR0 && r_pidx == 64'h0))
        else $error("parser not rearmed after end of buffer");

    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= EXT64_BYTES)
        else $error("extension byte count out of range");

endmodule

`default_nettype wire

### test/tb_top.sv
// Regression bench for websocket_frame_parser_core: header corner cases, long
// extended lengths and random buffers, each result checked against an in-bench deframer.
// Depends on wsfp_pkg and the channel interfaces in wsfp_if.sv.
`default_nettype none

module tb_top;
    import wsfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam int ENC_SHORT   = 0;
    localparam int ENC_EXT16   = 1;
    localparam int ENC_EXT64   = 2;

    logic i_clk;
    logic i_rst_n;

    wsfp_in_if  in_ch ();
    wsfp_out_if out_ch ();

    websocket_frame_parser_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    int src_idle_pct = 8;
    int snk_idle_pct = 74;
    int cycle_count  = 0;
    int beats_driven = 0;
    int buffers_sent = 0;
    int mismatches   = 0;
    int payload_beats = 0;
    int frames_done  = 0;
    int truncations  = 0;

    logic [7:0] frame_bytes[$];
    t_result    awaited_results[$];

    // Deframer state
    t_phase      dfm_phase   = PH_HDR0;
    logic [3:0]  ext_cnt     = '0;
    logic [3:0]  ext_need    = '0;
    logic        hold_fin    = 1'b0;
    logic [3:0]  hold_opcode = '0;
    logic        hold_masked = 1'b0;
    logic [63:0] len_acc     = '0;
    logic [7:0]  unmask_key[4] = '{default: 8'h00};
    logic [63:0] pay_idx     = '0;

    function automatic t_result frame_result(input t_kind kind, input logic [7:0] pb,
                                             input bit with_hdr);
        t_result r;
        r = '0;
        r.kind = kind;
        r.payload_byte = pb;
        if (with_hdr) begin
            r.fin_flag     = hold_fin;
            r.frame_opcode = hold_opcode;
            r.masked_flag  = hold_masked;
            r.frame_length = len_acc;
        end
        return r;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic eob);
        t_result step_q[$];
        bit      length_known;
        bit      header_end;
        length_known = 1'b0;
        header_end   = 1'b0;
        case (dfm_phase)
            PH_HDR0: begin
                hold_fin    = b[7];
                hold_opcode = b[3:0];
                hold_masked = 1'b0;
                len_acc     = '0;
                pay_idx     = '0;
                dfm_phase   = PH_HDR1;
            end
            PH_HDR1: begin
                hold_masked = b[7];
                len_acc     = '0;
                ext_cnt     = '0;
                if (b[6:0] == LEN_EXT16) begin
                    ext_need  = EXT16_BYTES;
                    dfm_phase = PH_EXT;
                end else if (b[6:0] == LEN_EXT64) begin
                    ext_need  = EXT64_BYTES;
                    dfm_phase = PH_EXT;
                end else begin
                    ext_need     = '0;
                    len_acc      = {57'd0, b[6:0]};
                    length_known = 1'b1;
                end
            end
            PH_EXT: begin
                len_acc = {len_acc[55:0], b};
                ext_cnt = ext_cnt + 4'd1;
                if (ext_cnt >= ext_need)
                    length_known = 1'b1;
            end
            PH_KEY: begin
                unmask_key[ext_cnt[1:0]] = b;
                ext_cnt = ext_cnt + 4'd1;
                if (ext_cnt >= KEY_BYTES)
                    header_end = 1'b1;
            end
            PH_PAY: begin
                step_q.push_back(frame_result(KIND_PAYLOAD,
                    hold_masked ? (b ^ unmask_key[pay_idx[1:0]]) : b, 1'b1));
                pay_idx = pay_idx + 64'd1;
                if (pay_idx >= len_acc) begin
                    step_q.push_back(frame_result(KIND_DONE, 8'h00, 1'b1));
                    dfm_phase = PH_SKIP;
                end
            end
            default: dfm_phase = PH_SKIP;
        endcase
        if (length_known) begin
            if (hold_masked) begin
                ext_cnt   = '0;
                dfm_phase = PH_KEY;
            end else begin
                header_end = 1'b1;
            end
        end
        if (header_end) begin
            pay_idx = '0;
            if (len_acc == 64'd0) begin
                step_q.push_back(frame_result(KIND_DONE, 8'h00, 1'b1));
                dfm_phase = PH_SKIP;
            end else begin
                dfm_phase = PH_PAY;
            end
        end
        if (eob) begin
            if (dfm_phase != PH_SKIP)
                step_q.push_back(frame_result(KIND_TRUNC, 8'h00, 1'b0));
            dfm_phase = PH_HDR0;
            ext_cnt   = '0;
            ext_need  = '0;
            pay_idx   = '0;
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            awaited_results.push_back(step_q[i]);
    endfunction

    function automatic void build_frame(input logic [7:0] hdr0, input bit masked, input int enc,
                                        input logic [63:0] len, input logic [31:0] key,
                                        input int pay_count, input int junk);
        frame_bytes.delete();
        frame_bytes.push_back(hdr0);
        case (enc)
            ENC_SHORT: frame_bytes.push_back({masked, len[6:0]});
            ENC_EXT16: begin
                frame_bytes.push_back({masked, LEN_EXT16});
                frame_bytes.push_back(len[15:8]);
                frame_bytes.push_back(len[7:0]);
            end
            default: begin
                frame_bytes.push_back({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    frame_bytes.push_back(len[8*i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                frame_bytes.push_back(key[8*i +: 8]);
        for (int i = 0; i < pay_count + junk; i++)
            frame_bytes.push_back(8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic eob);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid         = 1'b0;
            in_ch.data_byte     = 8'($urandom);
            in_ch.end_of_buffer = 1'($urandom);
            @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.data_byte     = data;
        in_ch.end_of_buffer = eob;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        deframe_byte(data, eob);
        beats_driven++;
    endtask

    // Send the first keep bytes of the built frame as one buffer
    task automatic send_buffer(input int keep);
        int count;
        count = (keep < frame_bytes.size()) ? keep : frame_bytes.size();
        for (int i = 0; i < count; i++)
            send_byte(frame_bytes[i], i == count - 1);
        buffers_sent++;
    endtask

    task automatic test_header_corners();
        build_frame(8'hFF, 1'b1, ENC_SHORT, 64'd5, 32'h0, 5, 0);
        send_buffer(1);
        build_frame(8'h89, 1'b0, ENC_SHORT, 64'd0, 32'h0, 0, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h0A, 1'b0, ENC_SHORT, 64'd0, 32'h0, 0, 2);
        send_buffer(frame_bytes.size());
        build_frame(8'hF1, 1'b1, ENC_SHORT, 64'd0, 32'hFFFF_FFFF, 0, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h02, 1'b0, ENC_EXT16, 64'd0, 32'h0, 0, 1);
        send_buffer(frame_bytes.size());
        build_frame(8'h8F, 1'b1, ENC_EXT64, 64'h8000_0000_0000_0001, 32'h1234_5678, 0, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h81, 1'b1, ENC_SHORT, 64'd2, 32'hA55A_00FF, 2, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h70, 1'b0, ENC_SHORT, 64'd3, 32'h0, 2, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h08, 1'b0, ENC_EXT16, 64'd4, 32'h0, 4, 0);
        send_buffer(3);
        build_frame(8'h09, 1'b1, ENC_SHORT, 64'd4, 32'hC3C3_3C3C, 4, 0);
        send_buffer(4);
    endtask

    task automatic test_extended_lengths();
        build_frame(8'h82, 1'b0, ENC_EXT16, 64'd126, 32'h0, 126, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h01, 1'b1, ENC_EXT16, 64'd300, $urandom, 300, 1);
        send_buffer(frame_bytes.size());
        build_frame(8'hC2, 1'b1, ENC_EXT64, 64'd2, $urandom, 2, 0);
        send_buffer(frame_bytes.size());
        build_frame(8'h8A, 1'b0, ENC_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 6, 0);
        send_buffer(frame_bytes.size());
    endtask

    task automatic test_random_buffers(input int byte_budget);
        int          stop_at;
        int          enc;
        int          roll;
        int          pay;
        int          keep;
        bit          masked;
        logic [63:0] len;
        stop_at = beats_driven + byte_budget;
        while (beats_driven < stop_at) begin
            if ($urandom_range(0, 99) < 10) begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 12))
                    frame_bytes.push_back(8'($urandom));
                send_buffer(frame_bytes.size());
            end else begin
                roll = $urandom_range(0, 99);
                enc  = (roll < 60) ? ENC_SHORT : (roll < 85) ? ENC_EXT16 : ENC_EXT64;
                roll = $urandom_range(0, 19);
                case (enc)
                    ENC_SHORT: len = (roll < 14) ? 64'($urandom_range(0, 8)) :
                                                   64'($urandom_range(0, 125));
                    ENC_EXT16: begin
                        if (roll < 15)
                            len = 64'($urandom_range(0, 12));
                        else if (roll < 19)
                            len = 64'($urandom_range(126, 320));
                        else
                            len = {48'd0, 16'($urandom)};
                    end
                    default: len = (roll < 14) ? 64'($urandom_range(0, 12)) :
                                                 {$urandom, $urandom};
                endcase
                masked = 1'($urandom);
                pay    = (len > 64'd320) ? int'($urandom_range(0, 20)) : int'(len);
                build_frame(8'($urandom), masked, enc, len, $urandom, pay,
                            ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3));
                keep = frame_bytes.size();
                if ($urandom_range(0, 99) < 15)
                    keep = $urandom_range(1, frame_bytes.size());
                send_buffer(keep);
            end
        end
    endtask

    function automatic bit result_matches(input t_result want, input t_result got);
        return (got.kind === want.kind) && (got.payload_byte === want.payload_byte) &&
               (got.fin_flag === want.fin_flag) && (got.frame_opcode === want.frame_opcode) &&
               (got.masked_flag === want.masked_flag) &&
               (got.frame_length === want.frame_length) && (got.last === want.last);
    endfunction

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind         = out_ch.kind;
            got.payload_byte = out_ch.payload_byte;
            got.fin_flag     = out_ch.fin_flag;
            got.frame_opcode = out_ch.frame_opcode;
            got.masked_flag  = out_ch.masked_flag;
            got.frame_length = out_ch.frame_length;
            got.last         = out_ch.last;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: kind=%0d pb=%02h len=%016h last=%0b",
                             got.kind, got.payload_byte, got.frame_length, got.last);
            end else begin
                want = awaited_results.pop_front();
                case (want.kind)
                    KIND_PAYLOAD: payload_beats++;
                    KIND_DONE:    frames_done++;
                    default:      truncations++;
                endcase
                if (!result_matches(want, got)) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display({"mismatch exp: kind=%0d pb=%02h fin=%0b op=%0h m=%0b",
                                  " len=%016h last=%0b"},
                                 want.kind, want.payload_byte, want.fin_flag, want.frame_opcode,
                                 want.masked_flag, want.frame_length, want.last);
                        $display({"         got: kind=%0d pb=%02h fin=%0b op=%0h m=%0b",
                                  " len=%016h last=%0b"},
                                 got.kind, got.payload_byte, got.fin_flag, got.frame_opcode,
                                 got.masked_flag, got.frame_length, got.last);
                    end
                end
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("websocket_frame_parser_core regression: fail");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = 8'h00;
        in_ch.end_of_buffer = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_header_corners();
        test_extended_lengths();
        test_random_buffers(360);
        src_idle_pct = 74;
        snk_idle_pct = 8;
        test_random_buffers(360);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_buffers(360);

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d bytes in %0d buffers under three idle mixes",
                 beats_driven, buffers_sent);
        $display("checked %0d payload beats, %0d complete frames, %0d truncations; %0d mismatches",
                 payload_beats, frames_done, truncations, mismatches);
        if (mismatches == 0)
            $display("websocket_frame_parser_core regression: pass");
        else
            $display("websocket_frame_parser_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/wsfp_pkg.sv
rtl/wsfp_if.sv
rtl/websocket_frame_parser_core.sv
test/tb_top.sv
